// ----- rtl/min_tracking_stack_top_defines.svh -----
// Assertion macros used by the min tracking stack datapath.
`ifndef MIN_TRACKING_STACK_TOP_DEFINES_SVH
`define MIN_TRACKING_STACK_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define MTS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define MTS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/mts_pkg.sv -----
// Types and constants shared by the min tracking stack modules.
package mts_pkg;

  localparam int DEPTH  = 64;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = 7;
  localparam int WORD_W = 32;

  localparam logic [WORD_W-1:0] EMPTY_MIN = 32'h7FFF_FFFF;
  localparam logic [CNT_W-1:0]  CAP_RESET = CNT_W'(DEPTH);

  typedef enum logic [1:0] {
    OP_PUSH  = 2'd0,
    OP_POP   = 2'd1,
    OP_QUERY = 2'd2
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_POPW
  } state_t;

  typedef struct packed {
    logic load;
    logic push_wr;
    logic pop_rd;
    logic finish_now;
    logic finish_pop;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_push;
    logic is_pop;
    logic full;
    logic empty;
  } dp_stat_t;

endpackage

// ----- rtl/min_tracking_stack_top.sv -----
// Top level of the min tracking stack: controller, datapath and ports.
// A push or query result is registered in the execute state and then strobed on out_valid.
// A pop on a non-empty stack passes through an extra wait state for the registered RAM read first.
// A new request is accepted in the cycle busy drops; no new request is taken while one is in progress.
// Synchronous active-low reset empties the stack and sets capacity to 64; RAMs are not cleared.
// Results are strobed for one cycle and the receiver cannot stall them.
module min_tracking_stack_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [1:0]                        in_opcode,
  input  logic signed [mts_pkg::WORD_W-1:0] in_push_value,
  input  logic                              cfg_we,
  input  logic [mts_pkg::CNT_W-1:0]         cfg_wdata,
  output logic                              out_valid,
  output logic signed [mts_pkg::WORD_W-1:0] out_popped_value,
  output logic signed [mts_pkg::WORD_W-1:0] out_minimum,
  output logic                              out_is_full,
  output logic                              out_is_empty,
  output logic [mts_pkg::CNT_W-1:0]         out_entry_count,
  output logic [1:0]                        out_status
);
  import mts_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  mts_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .busy  (busy),
    .cmd   (cmd)
  );

  mts_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_opcode        (in_opcode),
    .in_push_value    (in_push_value),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .out_valid        (out_valid),
    .out_popped_value (out_popped_value),
    .out_minimum      (out_minimum),
    .out_is_full      (out_is_full),
    .out_is_empty     (out_is_empty),
    .out_entry_count  (out_entry_count),
    .out_status       (out_status)
  );

endmodule

// ----- rtl/mts_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module mts_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/mts_ctrl.sv -----
// Controller state machine sequencing each stack request.
module mts_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  mts_pkg::dp_stat_t  stat,
  output logic               busy,
  output mts_pkg::ctrl_cmd_t cmd
);
  import mts_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (stat.is_pop && !stat.empty) begin
          state_nxt = S_POPW;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_POPW: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    case (state_r)
      S_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      S_EXEC: begin
        if (stat.is_pop && !stat.empty) begin
          cmd.pop_rd = 1'b1;
        end else begin
          cmd.finish_now = 1'b1;
          cmd.push_wr    = stat.is_push && !stat.full;
        end
      end
      S_POPW: cmd.finish_pop = 1'b1;
      default: busy = 1'b1;
    endcase
  end

endmodule

// ----- rtl/mts_dp.sv -----
// Datapath holding the stack stores, count, running minimum and result registers.
`include "min_tracking_stack_top_defines.svh"
module mts_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  mts_pkg::ctrl_cmd_t                cmd,
  output mts_pkg::dp_stat_t                 stat,
  input  logic [1:0]                        in_opcode,
  input  logic signed [mts_pkg::WORD_W-1:0] in_push_value,
  input  logic                              cfg_we,
  input  logic [mts_pkg::CNT_W-1:0]         cfg_wdata,
  output logic                              out_valid,
  output logic signed [mts_pkg::WORD_W-1:0] out_popped_value,
  output logic signed [mts_pkg::WORD_W-1:0] out_minimum,
  output logic                              out_is_full,
  output logic                              out_is_empty,
  output logic [mts_pkg::CNT_W-1:0]         out_entry_count,
  output logic [1:0]                        out_status
);
  import mts_pkg::*;

  logic [1:0]        op_r;
  logic [WORD_W-1:0] val_r;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [WORD_W-1:0] min_r, min_nxt;
  logic [CNT_W-1:0]  cap_r;
  logic [CNT_W-1:0]  cap_eff;

  logic              valid_r;
  logic [WORD_W-1:0] popped_r, popped_nxt;
  logic [WORD_W-1:0] res_min_r;
  logic              full_r, empty_r;
  logic [CNT_W-1:0]  res_cnt_r;
  logic [1:0]        status_r, status_nxt;

  logic [WORD_W-1:0] word_rd, pmin_rd, push_min;
  logic [CNT_W-1:0]  cnt_m1, cnt_m2;
  logic              finish;

  assign cap_eff = (cap_r == '0) ? CNT_W'(1) :
                   (cap_r > CNT_W'(DEPTH)) ? CNT_W'(DEPTH) : cap_r;

  assign stat.is_push = (op_r == OP_PUSH);
  assign stat.is_pop  = (op_r == OP_POP);
  assign stat.full    = (count_r >= cap_eff);
  assign stat.empty   = (count_r == '0);

  assign cnt_m1   = count_r - CNT_W'(1);
  assign cnt_m2   = count_r - CNT_W'(2);
  assign push_min = ($signed(val_r) < $signed(min_r)) ? val_r : min_r;
  assign finish   = cmd.finish_now || cmd.finish_pop;

  mts_ram #(.WIDTH(WORD_W), .DEPTH(DEPTH)) u_words (
    .clk   (clk),
    .we    (cmd.push_wr),
    .waddr (count_r[ADDR_W-1:0]),
    .wdata (val_r),
    .raddr (cnt_m1[ADDR_W-1:0]),
    .rdata (word_rd)
  );

  mts_ram #(.WIDTH(WORD_W), .DEPTH(DEPTH)) u_pmin (
    .clk   (clk),
    .we    (cmd.push_wr),
    .waddr (count_r[ADDR_W-1:0]),
    .wdata (push_min),
    .raddr (cnt_m2[ADDR_W-1:0]),
    .rdata (pmin_rd)
  );

  always_comb begin
    count_nxt  = count_r;
    min_nxt    = min_r;
    popped_nxt = '0;
    status_nxt = ST_OK;
    if (cmd.finish_pop) begin
      count_nxt  = cnt_m1;
      popped_nxt = word_rd;
      min_nxt    = (count_r == CNT_W'(1)) ? EMPTY_MIN : pmin_rd;
    end else if (cmd.finish_now) begin
      if (cmd.push_wr) begin
        count_nxt = count_r + CNT_W'(1);
        min_nxt   = push_min;
      end else if (stat.is_push) begin
        status_nxt = ST_OVERFLOW;
      end else if (stat.is_pop) begin
        status_nxt = ST_UNDERFLOW;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      min_r   <= EMPTY_MIN;
      cap_r   <= CAP_RESET;
      valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      min_r   <= min_nxt;
      valid_r <= finish;
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= in_opcode;
      val_r <= in_push_value;
    end
    if (finish) begin
      popped_r  <= popped_nxt;
      res_min_r <= min_nxt;
      full_r    <= (count_nxt >= cap_eff);
      empty_r   <= (count_nxt == '0);
      res_cnt_r <= count_nxt;
      status_r  <= status_nxt;
    end
  end

  assign out_valid        = valid_r;
  assign out_popped_value = popped_r;
  assign out_minimum      = res_min_r;
  assign out_is_full      = full_r;
  assign out_is_empty     = empty_r;
  assign out_entry_count  = res_cnt_r;
  assign out_status       = status_r;

  `MTS_ASSERT_IMP(a_count_range, clk, rst_n, 1'b1, count_r <= CNT_W'(DEPTH), "count above depth")
  `MTS_ASSERT_IMP(a_empty_min, clk, rst_n, count_r == '0, min_r == EMPTY_MIN, "empty minimum wrong")
  `MTS_ASSERT_IMP(a_pop_nonempty, clk, rst_n, cmd.pop_rd || cmd.finish_pop, count_r != '0, "pop on empty")
  `MTS_ASSERT_NXT(a_pop_follows, clk, rst_n, cmd.pop_rd, cmd.finish_pop, "pop read not completed")
  `MTS_ASSERT_NXT(a_push_grows, clk, rst_n, cmd.push_wr, count_r == $past(count_r) + CNT_W'(1), "push count")

endmodule

// ----- bench/min_tracking_stack_top_tb.sv -----
// Self-checking testbench for the min tracking stack: directed table, then random phases.
`timescale 1ns / 100ps

module min_tracking_stack_top_tb;
  import mts_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int unsigned RUN_LIMIT = 300000;
  localparam int unsigned PHASES = 12;
  localparam int unsigned PHASE_LEN = 150;

  typedef struct packed {
    logic [WORD_W-1:0] popped;
    logic [WORD_W-1:0] minimum;
    logic              full;
    logic              empty;
    logic [CNT_W-1:0]  count;
    status_t           status;
  } stack_result_t;

  typedef struct packed {
    logic              is_cfg;
    logic [CNT_W-1:0]  cap;
    logic [1:0]        op;
    logic [WORD_W-1:0] value;
    logic              typed;
    stack_result_t     res;
  } dir_row_t;

  localparam stack_result_t RES_EMPTY = '{32'd0, EMPTY_MIN, 1'b0, 1'b1, 7'd0, ST_OK};
  localparam stack_result_t RES_UNDER = '{32'd0, EMPTY_MIN, 1'b0, 1'b1, 7'd0, ST_UNDERFLOW};
  localparam stack_result_t RES_NONE  = '{32'd0, 32'd0, 1'b0, 1'b0, 7'd0, ST_OK};

  localparam dir_row_t DIRECTED [0:30] = '{
    '{1'b0, 7'd0,   OP_QUERY,  32'h0000_0000, 1'b1, RES_EMPTY},
    '{1'b0, 7'd0,   OP_POP,    32'h0000_0000, 1'b1, RES_UNDER},
    '{1'b0, 7'd0,   OP_UNUSED, 32'hFFFF_FFFF, 1'b1, RES_EMPTY},
    '{1'b0, 7'd0,   OP_PUSH,   32'h7FFF_FFFF, 1'b0, RES_NONE},
    '{1'b0, 7'd0,   OP_PUSH,   32'h8000_0000, 1'b0, RES_NONE},
    '{1'b0, 7'd0,   OP_PUSH,   32'h0000_0000, 1'b0, RES_NONE},
    '{1'b0, 7'd0,   OP_PUSH,   32'hFFFF_FFFF, 1'b0, RES_NONE},
    '{1'b0, 7'd0,   OP_QUERY,  32'hA5A5_5A5A, 1'b0, RES_NONE},
    '{1'b0, 7'd0,   OP_POP,    32'h1234_5678, 1'b0, RES_NONE},
    '{1'b0, 7'd0,   OP_POP,    32'h0000_0000, 1'b0, RES_NONE},
    '{1'b0, 7'd0,   OP_POP,    32'h0000_0000, 1'b0, RES_NONE},
    '{1'b0, 7'd0,   OP_POP,    32'h0000_0000, 1'b0, RES_NONE},
    '{1'b0, 7'd0,   OP_POP,    32'h0000_0000, 1'b1, RES_UNDER},
    '{1'b1, 7'd1,   OP_QUERY,  32'h0000_0000, 1'b0, RES_NONE},
    '{1'b0, 7'd0,   OP_PUSH,   32'h0000_0005, 1'b0, RES_NONE},
    '{1'b0, 7'd0,   OP_PUSH,   32'h0000_0006, 1'b0, RES_NONE},
    '{1'b1, 7'd0,   OP_QUERY,  32'h0000_0000, 1'b0, RES_NONE},
    '{1'b0, 7'd0,   OP_PUSH,   32'h0000_0007, 1'b0, RES_NONE},
    '{1'b1, 7'd127, OP_QUERY,  32'h0000_0000, 1'b0, RES_NONE},
    '{1'b0, 7'd0,   OP_QUERY,  32'h0000_0000, 1'b0, RES_NONE},
    '{1'b0, 7'd0,   OP_PUSH,   32'h0000_0003, 1'b0, RES_NONE},
    '{1'b0, 7'd0,   OP_PUSH,   32'h0000_0003, 1'b0, RES_NONE},
    '{1'b0, 7'd0,   OP_PUSH,   32'h0000_0009, 1'b0, RES_NONE},
    '{1'b1, 7'd2,   OP_QUERY,  32'h0000_0000, 1'b0, RES_NONE},
    '{1'b0, 7'd0,   OP_QUERY,  32'h0000_0000, 1'b0, RES_NONE},
    '{1'b0, 7'd0,   OP_PUSH,   32'h0000_0001, 1'b0, RES_NONE},
    '{1'b0, 7'd0,   OP_POP,    32'h0000_0000, 1'b0, RES_NONE},
    '{1'b0, 7'd0,   OP_POP,    32'h0000_0000, 1'b0, RES_NONE},
    '{1'b0, 7'd0,   OP_POP,    32'h0000_0000, 1'b0, RES_NONE},
    '{1'b0, 7'd0,   OP_POP,    32'h0000_0000, 1'b0, RES_NONE},
    '{1'b1, 7'd64,  OP_QUERY,  32'h0000_0000, 1'b0, RES_NONE}
  };

  localparam logic [CNT_W-1:0] PHASE_CAP [0:PHASES-1] =
    '{7'd64, 7'd3, 7'd127, 7'd0, 7'd64, 7'd1, 7'd40, 7'd64, 7'd8, 7'd127, 7'd2, 7'd64};

  logic                     clk;
  logic                     rst_n;
  logic                     start;
  logic                     busy;
  logic [1:0]               in_opcode;
  logic signed [WORD_W-1:0] in_push_value;
  logic                     cfg_we;
  logic [CNT_W-1:0]         cfg_wdata;
  logic                     out_valid;
  logic signed [WORD_W-1:0] out_popped_value;
  logic signed [WORD_W-1:0] out_minimum;
  logic                     out_is_full;
  logic                     out_is_empty;
  logic [CNT_W-1:0]         out_entry_count;
  logic [1:0]               out_status;

  logic signed [WORD_W-1:0] word_mem [0:DEPTH-1];
  logic signed [WORD_W-1:0] min_mem [0:DEPTH-1];
  int unsigned              held_count;
  logic [CNT_W-1:0]         capacity_reg;

  stack_result_t pending_results [$];
  int unsigned   error_count;
  int unsigned   cycle_count;
  int unsigned   idle_pct;

  min_tracking_stack_top u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_opcode        (in_opcode),
    .in_push_value    (in_push_value),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .out_valid        (out_valid),
    .out_popped_value (out_popped_value),
    .out_minimum      (out_minimum),
    .out_is_full      (out_is_full),
    .out_is_empty     (out_is_empty),
    .out_entry_count  (out_entry_count),
    .out_status       (out_status)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  function automatic stack_result_t apply_request(input logic [1:0] op,
                                                  input logic signed [WORD_W-1:0] val);
    stack_result_t      r;
    int unsigned        cap;
    logic signed [WORD_W-1:0] below;
    r = RES_NONE;
    cap = (capacity_reg == 0) ? 1 : (capacity_reg > DEPTH) ? DEPTH : capacity_reg;
    if (op == OP_PUSH) begin
      if (held_count >= cap) begin
        r.status = ST_OVERFLOW;
      end else begin
        below = (held_count == 0) ? EMPTY_MIN : min_mem[held_count-1];
        word_mem[held_count] = val;
        min_mem[held_count] = (val < below) ? val : below;
        held_count++;
      end
    end else if (op == OP_POP) begin
      if (held_count == 0) begin
        r.status = ST_UNDERFLOW;
      end else begin
        held_count--;
        r.popped = word_mem[held_count];
      end
    end
    r.minimum = (held_count == 0) ? EMPTY_MIN : min_mem[held_count-1];
    r.full = (held_count >= cap);
    r.empty = (held_count == 0);
    r.count = held_count[CNT_W-1:0];
    return r;
  endfunction

  // Called just after a falling edge; returns just after the falling edge that
  // follows acceptance, with start still high.
  task automatic issue_request(input logic [1:0] op, input logic [WORD_W-1:0] val,
                               input logic typed, input stack_result_t typed_res);
    stack_result_t r;
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    in_opcode <= op;
    in_push_value <= val;
    do @(posedge clk); while (busy);
    r = apply_request(op, val);
    pending_results.push_back(typed ? typed_res : r);
    @(negedge clk);
  endtask

  task automatic write_capacity(input logic [CNT_W-1:0] cap);
    start <= 1'b0;
    while (pending_results.size() != 0 || busy) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= cap;
    capacity_reg = cap;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic compare_field(input string name, input logic [WORD_W-1:0] want,
                               input logic [WORD_W-1:0] got);
    if (got !== want) begin
      error_count++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : result_monitor
    stack_result_t want;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        error_count++;
        $display("%0t: unexpected result, expected none, actual popped %h minimum %h",
                 $time, out_popped_value, out_minimum);
      end else begin
        want = pending_results.pop_front();
        compare_field("popped_value", want.popped, out_popped_value);
        compare_field("minimum", want.minimum, out_minimum);
        compare_field("is_full", want.full, out_is_full);
        compare_field("is_empty", want.empty, out_is_empty);
        compare_field("entry_count", want.count, out_entry_count);
        compare_field("status", want.status, out_status);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > RUN_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, pending_results.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    int unsigned      ph;
    int unsigned      k;
    int unsigned      pick;
    logic [1:0]       op;
    logic [WORD_W-1:0] val;
    logic [CNT_W-1:0] cap;
    rst_n = 1'b0;
    start = 1'b0;
    in_opcode = OP_QUERY;
    in_push_value = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    error_count = 0;
    cycle_count = 0;
    idle_pct = 13;
    held_count = 0;
    capacity_reg = CAP_RESET;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (k = 0; k < $size(DIRECTED); k++) begin
      if (DIRECTED[k].is_cfg) begin
        write_capacity(DIRECTED[k].cap);
      end else begin
        issue_request(DIRECTED[k].op, DIRECTED[k].value, DIRECTED[k].typed,
                      DIRECTED[k].res);
      end
    end

    // Each phase fills the stack for most of its length and then drains it, so
    // full, overflow and underflow are all reached under several capacities.
    for (ph = 0; ph < PHASES; ph++) begin
      cap = (ph == 6) ? 7'($urandom_range(1, 127)) : PHASE_CAP[ph];
      write_capacity(cap);
      idle_pct = (ph >= 4 && ph < 7) ? 0 : 13;
      for (k = 0; k < PHASE_LEN; k++) begin
        pick = $urandom_range(0, 99);
        if (k < 100) begin
          op = (pick < 75) ? OP_PUSH : (pick < 90) ? OP_POP : (pick < 95) ? OP_QUERY : OP_UNUSED;
        end else begin
          op = (pick < 80) ? OP_POP : (pick < 90) ? OP_PUSH : (pick < 95) ? OP_QUERY : OP_UNUSED;
        end
        case ($urandom_range(0, 9))
          0: begin
            val = 32'h8000_0000;
          end
          1: begin
            val = 32'h7FFF_FFFF;
          end
          2, 3, 4: begin
            val = $urandom_range(0, 16) - 8;
          end
          default: begin
            val = $urandom;
          end
        endcase
        issue_request(op, val, 1'b0, RES_NONE);
      end
    end

    start <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/mts_pkg.sv
rtl/mts_ram.sv
rtl/mts_ctrl.sv
rtl/mts_dp.sv
rtl/min_tracking_stack_top.sv
bench/min_tracking_stack_top_tb.sv
